@@ src/assert_macros.svh @@
// Assertion helpers used by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is low.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/nrsc_pkg.sv @@
`timescale 1ns / 1ps

package nrsc_pkg;

    // Default limits of the line store and of the sentence.
    localparam int LINE_STORE_BYTES_DEF   = 128;
    localparam int MAX_SENTENCE_BYTES_DEF = 82;

    // Fixed widths taken from the item fields.
    localparam int BYTE_W = 8;
    localparam int LEN_W  = 8;
    localparam int UTC_W  = 20;

    localparam logic [UTC_W-1:0] UTC_LIMIT = UTC_W'(999999);

    // Queue between the front and the back part.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Character codes.
    localparam logic [BYTE_W-1:0] CH_DOLLAR  = 8'h24;
    localparam logic [BYTE_W-1:0] CH_STAR    = 8'h2A;
    localparam logic [BYTE_W-1:0] CH_COMMA   = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_DOT     = 8'h2E;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    localparam logic [2:0] PREFIX_LEN = 3'd6;

    // Checksum phase of the current line.
    typedef enum logic [2:0] {
        PH_DOLLAR,
        PH_SUM,
        PH_CHECK1,
        PH_CHECK2,
        PH_DONE,
        PH_FAIL
    } t_phase;

    // RMC parse step of the current line.
    typedef enum logic [3:0] {
        FD_PREFIX,
        FD_COMMA,
        FD_UTC_FIRST,
        FD_UTC,
        FD_FRAC_FIRST,
        FD_FRAC,
        FD_STATUS,
        FD_STOP,
        FD_HELD
    } t_field;

    // One classified byte as it travels from the front to the back part.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              is_end;
        logic              is_nul;
        logic              is_star;
        logic              is_digit;
        logic              idx_ok;
    } t_item;

    // Characters of the RMC sentence prefix.
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] pos);
        logic [BYTE_W-1:0] c;
        case (pos)
            3'd0:    c = CH_DOLLAR;
            3'd1:    c = 8'h47;
            3'd2:    c = 8'h50;
            3'd3:    c = 8'h52;
            3'd4:    c = 8'h4D;
            3'd5:    c = 8'h43;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    // Upper-case hex character of a nibble.
    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] c;
        if (nib < 4'd10) begin
            c = CH_ZERO + {4'd0, nib};
        end else begin
            c = CH_UPPER_A + {4'd0, nib} - 8'd10;
        end
        return c;
    endfunction

endpackage

@@ src/nrsc_if.sv @@
`timescale 1ns / 1ps

// Channel that carries received bytes.
interface nrsc_in_if import nrsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Channel that carries one result per line.
interface nrsc_out_if import nrsc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             checksum_ok;
    logic             rmc_found;
    logic             fix_active;
    logic [UTC_W-1:0] utc_time;

    modport source (output valid, output checksum_ok, output rmc_found,
                    output fix_active, output utc_time, input ready);
    modport sink   (input valid, input checksum_ok, input rmc_found,
                    input fix_active, input utc_time, output ready);
endinterface

@@ src/nmea_rmc_sentence_checker_top.sv @@
`timescale 1ns / 1ps
// Throughput: one byte per cycle while the queue is not full.
// A line end passes the queue into the output register; a result leaves it when taken.
// A four-item queue between front and back absorbs output stalls before ready drops.
// Reset (synchronous, active low) empties the queue and clears the line state.

module nmea_rmc_sentence_checker_top import nrsc_pkg::*; #(
    parameter int LINE_STORE_BYTES   = LINE_STORE_BYTES_DEF,
    parameter int MAX_SENTENCE_BYTES = MAX_SENTENCE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nrsc_in_if.sink    i_in,
    nrsc_out_if.source o_out
);

    t_item q_in_item;
    t_item q_out_item;
    logic  q_push;
    logic  q_pop;
    logic  q_full;
    logic  q_empty;

    // Front: counts and classifies bytes.
    nrsc_front #(
        .LINE_STORE_BYTES   (LINE_STORE_BYTES),
        .MAX_SENTENCE_BYTES (MAX_SENTENCE_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_item  (q_in_item)
    );

    // Queue between the two parts.
    nrsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .i_pop   (q_pop),
        .o_item  (q_out_item),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: checksum and RMC parsing, result register.
    nrsc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (q_out_item),
        .i_empty (q_empty),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

@@ src/nrsc_queue.sv @@
`timescale 1ns / 1ps

module nrsc_queue import nrsc_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    input  logic  i_pop,
    output t_item o_item,
    output logic  o_full,
    output logic  o_empty
);

    t_item             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ src/nrsc_front.sv @@
`timescale 1ns / 1ps

module nrsc_front import nrsc_pkg::*; #(
    parameter int LINE_STORE_BYTES   = LINE_STORE_BYTES_DEF,
    parameter int MAX_SENTENCE_BYTES = MAX_SENTENCE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrsc_in_if.sink     i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_item       o_item
);

    localparam logic [LEN_W-1:0] STORE_LIM = LEN_W'(LINE_STORE_BYTES);
    localparam logic [LEN_W-1:0] SENT_LIM  = LEN_W'(MAX_SENTENCE_BYTES);

    logic [LEN_W-1:0] r_len;
    logic [LEN_W-1:0] n_len;
    logic [BYTE_W-1:0] b;

    assign b          = i_in.rx_byte;
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Classify the byte; a newline or a full line store ends the line.
    always_comb begin
        o_item.data     = b;
        o_item.is_end   = (b == CH_NEWLINE) || (r_len >= STORE_LIM);
        o_item.is_nul   = (b == CH_NUL);
        o_item.is_star  = (b == CH_STAR);
        o_item.is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
        o_item.idx_ok   = (r_len < SENT_LIM);
        n_len           = r_len;
        if (o_push) begin
            n_len = o_item.is_end ? '0 : r_len + 1'b1;
        end
    end

    // Count of bytes held in the current line.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= '0;
        end else begin
            r_len <= n_len;
        end
    end

endmodule

@@ src/nrsc_back.sv @@
`timescale 1ns / 1ps

module nrsc_back import nrsc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_item       i_item,
    input  logic        i_empty,
    output logic        o_pop,
    nrsc_out_if.source  o_out
);

    t_phase            r_phase, n_phase;
    t_field            r_field, n_field;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic [BYTE_W-1:0] r_c1, n_c1;
    logic [BYTE_W-1:0] r_c2, n_c2;
    logic [2:0]        r_ppos, n_ppos;
    logic [BYTE_W-1:0] r_status, n_status;
    logic [UTC_W-1:0]  r_utc, n_utc;

    logic              r_ovalid, n_ovalid;
    logic              r_ok, n_ok;
    logic              r_rmc, n_rmc;
    logic              r_fix, n_fix;
    logic [UTC_W-1:0]  r_outc, n_outc;

    logic              out_free;
    logic [BYTE_W-1:0] b;
    logic [UTC_W+3:0]  utc_mul;
    logic              ok, rmc, fix;

    assign b        = i_item.data;
    assign out_free = !r_ovalid || o_out.ready;
    // A line end waits for room in the output register; other bytes always go.
    assign o_pop    = !i_empty && (!i_item.is_end || out_free);

    // Running UTC value times ten plus the new digit.
    assign utc_mul = {r_utc, 3'd0} + {2'd0, r_utc, 1'b0}
                   + {(UTC_W + 4 - 4)'(0), b[3:0]};

    // Line verdict from the state held so far.
    assign ok  = (r_phase == PH_DONE) && (r_c1 == hex_char(r_xor[7:4]))
              && (r_c2 == hex_char(r_xor[3:0]));
    assign rmc = ok && (r_ppos == PREFIX_LEN);
    assign fix = rmc && (r_field == FD_HELD) && (r_status == CH_UPPER_A);

    // Next state of both parsers and of the output register.
    always_comb begin
        n_phase  = r_phase;
        n_field  = r_field;
        n_xor    = r_xor;
        n_c1     = r_c1;
        n_c2     = r_c2;
        n_ppos   = r_ppos;
        n_status = r_status;
        n_utc    = r_utc;
        n_ovalid = r_ovalid && !o_out.ready;
        n_ok     = r_ok;
        n_rmc    = r_rmc;
        n_fix    = r_fix;
        n_outc   = r_outc;

        if (o_pop && i_item.is_end) begin
            n_ovalid = 1'b1;
            n_ok     = ok;
            n_rmc    = rmc;
            n_fix    = fix;
            n_outc   = rmc ? r_utc : '0;
            n_phase  = PH_DOLLAR;
            n_field  = FD_PREFIX;
            n_xor    = '0;
            n_c1     = '0;
            n_c2     = '0;
            n_ppos   = '0;
            n_status = '0;
            n_utc    = '0;
        end else if (o_pop) begin
            // Checksum parser.
            case (r_phase)
                PH_DOLLAR: begin
                    n_phase = (b == CH_DOLLAR) ? PH_SUM : PH_FAIL;
                end
                PH_SUM: begin
                    if (i_item.is_nul) begin
                        n_phase = PH_FAIL;
                    end else if (i_item.is_star) begin
                        n_phase = i_item.idx_ok ? PH_CHECK1 : PH_FAIL;
                    end else if (!i_item.idx_ok) begin
                        n_phase = PH_FAIL;
                    end else begin
                        n_xor = r_xor ^ b;
                    end
                end
                PH_CHECK1: begin
                    n_c1    = b;
                    n_phase = i_item.is_nul ? PH_FAIL : PH_CHECK2;
                end
                PH_CHECK2: begin
                    n_c2    = b;
                    n_phase = i_item.is_nul ? PH_FAIL : PH_DONE;
                end
                default: begin
                end
            endcase

            // RMC parser; the zero byte stops it unless it has already finished.
            if (i_item.is_nul && (r_field != FD_STOP) && (r_field != FD_HELD)) begin
                n_field = FD_STOP;
            end else begin
                case (r_field)
                    FD_PREFIX: begin
                        if ((r_ppos < PREFIX_LEN) && (b == prefix_char(r_ppos))) begin
                            n_ppos = r_ppos + 1'b1;
                            if (r_ppos == PREFIX_LEN - 1'b1) begin
                                n_field = FD_COMMA;
                            end
                        end else begin
                            n_field = FD_STOP;
                        end
                    end
                    FD_COMMA: begin
                        n_field = (b == CH_COMMA) ? FD_UTC_FIRST : FD_STOP;
                    end
                    FD_UTC_FIRST, FD_UTC: begin
                        if (i_item.is_digit) begin
                            n_utc   = (utc_mul > {4'd0, UTC_LIMIT}) ? UTC_LIMIT
                                                                    : utc_mul[UTC_W-1:0];
                            n_field = FD_UTC;
                        end else if ((r_field == FD_UTC) && (b == CH_DOT)) begin
                            n_field = FD_FRAC_FIRST;
                        end else begin
                            n_field = FD_STOP;
                        end
                    end
                    FD_FRAC_FIRST, FD_FRAC: begin
                        if (i_item.is_digit) begin
                            n_field = FD_FRAC;
                        end else if ((r_field == FD_FRAC) && (b == CH_COMMA)) begin
                            n_field = FD_STATUS;
                        end else begin
                            n_field = FD_STOP;
                        end
                    end
                    FD_STATUS: begin
                        n_status = b;
                        n_field  = FD_HELD;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_DOLLAR;
            r_field  <= FD_PREFIX;
            r_xor    <= '0;
            r_c1     <= '0;
            r_c2     <= '0;
            r_ppos   <= '0;
            r_status <= '0;
            r_utc    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_field  <= n_field;
            r_xor    <= n_xor;
            r_c1     <= n_c1;
            r_c2     <= n_c2;
            r_ppos   <= n_ppos;
            r_status <= n_status;
            r_utc    <= n_utc;
            r_ovalid <= n_ovalid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_rmc  <= n_rmc;
        r_fix  <= n_fix;
        r_outc <= n_outc;
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.checksum_ok = r_ok;
    assign o_out.rmc_found   = r_rmc;
    assign o_out.fix_active  = r_fix;
    assign o_out.utc_time    = r_outc;

endmodule

@@ src/nrsc_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nrsc_checker import nrsc_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic             i_ok,
    input logic             i_rmc,
    input logic             i_fix,
    input logic [UTC_W-1:0] i_utc
);

    // Result flags are nested: fix needs rmc, rmc needs a good checksum.
    `ASSERT_IMPL(a_rmc_needs_ok, i_clk, i_rst_n, i_out_valid && i_rmc, i_ok, "rmc without checksum")
    `ASSERT_IMPL(a_fix_needs_rmc, i_clk, i_rst_n, i_out_valid && i_fix, i_rmc, "fix without rmc")

    // UTC is zero unless an RMC sentence was found, and never exceeds the limit.
    `ASSERT_IMPL(a_utc_range, i_clk, i_rst_n, i_out_valid, (i_rmc || (i_utc == '0)) && (i_utc <= UTC_LIMIT), "bad utc value")

    // A stalled result holds.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_ok) && $stable(i_rmc) && $stable(i_fix) && $stable(i_utc), "result changed under stall")

endmodule

bind nmea_rmc_sentence_checker_top nrsc_checker u_nrsc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_ok        (o_out.checksum_ok),
    .i_rmc       (o_out.rmc_found),
    .i_fix       (o_out.fix_active),
    .i_utc       (o_out.utc_time)
);

@@ tb/sv/nrsc_line_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, predicts one verdict per received line and compares
// every result item with the oldest outstanding verdict.
module nrsc_line_checker import nrsc_pkg::*; #(
    parameter int LINE_STORE_BYTES   = LINE_STORE_BYTES_DEF,
    parameter int MAX_SENTENCE_BYTES = MAX_SENTENCE_BYTES_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    nrsc_in_if   i_bytes,
    nrsc_out_if  i_results,
    output int   o_fail_count,
    output int   o_pending
);

    // Verdict expected for one finished line.
    typedef struct packed {
        logic             checksum_ok;
        logic             rmc_found;
        logic             fix_active;
        logic [UTC_W-1:0] utc_time;
    } t_line_verdict;

    localparam logic [47:0] RMC_TAG = "$GPRMC";

    t_line_verdict verdict_q [$];
    int            fault_count = 0;

    // Shadow state of the line being received.
    logic [LEN_W-1:0]  held_bytes;
    logic [BYTE_W-1:0] sum_xor;
    t_phase            sum_phase;
    logic [BYTE_W-1:0] check_hi;
    logic [BYTE_W-1:0] check_lo;
    logic [2:0]        tag_pos;
    t_field            rmc_step;
    logic [BYTE_W-1:0] status_byte;
    logic [UTC_W-1:0]  utc_value;

    // Upper-case ASCII hex digit of a nibble.
    function automatic logic [BYTE_W-1:0] nibble_ascii(input logic [3:0] n);
        return (n > 4'd9) ? (8'h37 + {4'h0, n}) : (CH_ZERO + {4'h0, n});
    endfunction

    function automatic logic [BYTE_W-1:0] rmc_tag_char(input int pos);
        return RMC_TAG[8 * (5 - pos) +: 8];
    endfunction

    function automatic logic is_decimal(input logic [BYTE_W-1:0] b);
        return (b >= CH_ZERO) && (b <= CH_NINE);
    endfunction

    task automatic clear_line();
        held_bytes  = '0;
        sum_xor     = '0;
        sum_phase   = PH_DOLLAR;
        check_hi    = '0;
        check_lo    = '0;
        tag_pos     = '0;
        rmc_step    = FD_PREFIX;
        status_byte = '0;
        utc_value   = '0;
    endtask

    // Checksum framing: '$', XOR up to '*', then two check characters.
    task automatic track_checksum(input logic [BYTE_W-1:0] b);
        case (sum_phase)
            PH_DOLLAR: begin
                sum_phase = (b == CH_DOLLAR) ? PH_SUM : PH_FAIL;
            end
            PH_SUM: begin
                if (b == CH_NUL) begin
                    sum_phase = PH_FAIL;
                end else if (b == CH_STAR) begin
                    sum_phase = (int'(held_bytes) < MAX_SENTENCE_BYTES) ? PH_CHECK1 : PH_FAIL;
                end else if (int'(held_bytes) >= MAX_SENTENCE_BYTES) begin
                    sum_phase = PH_FAIL;
                end else begin
                    sum_xor = sum_xor ^ b;
                end
            end
            PH_CHECK1: begin
                check_hi  = b;
                sum_phase = (b == CH_NUL) ? PH_FAIL : PH_CHECK2;
            end
            PH_CHECK2: begin
                check_lo  = b;
                sum_phase = (b == CH_NUL) ? PH_FAIL : PH_DONE;
            end
            default: ;
        endcase
    endtask

    // RMC grammar: prefix, comma, UTC digits, dot, fraction digits, comma, status.
    task automatic track_rmc(input logic [BYTE_W-1:0] b);
        logic [31:0] grown;
        if (b == CH_NUL && rmc_step < FD_STOP) begin
            rmc_step = FD_STOP;
        end else begin
            case (rmc_step)
                FD_PREFIX: begin
                    if (tag_pos < PREFIX_LEN && b == rmc_tag_char(int'(tag_pos))) begin
                        tag_pos = tag_pos + 3'd1;
                        if (tag_pos == PREFIX_LEN) begin
                            rmc_step = FD_COMMA;
                        end
                    end else begin
                        rmc_step = FD_STOP;
                    end
                end
                FD_COMMA: begin
                    rmc_step = (b == CH_COMMA) ? FD_UTC_FIRST : FD_STOP;
                end
                FD_UTC_FIRST, FD_UTC: begin
                    if (is_decimal(b)) begin
                        grown     = 32'(utc_value) * 32'd10 + 32'(b - CH_ZERO);
                        utc_value = (grown > 32'(UTC_LIMIT)) ? UTC_LIMIT : UTC_W'(grown);
                        rmc_step  = FD_UTC;
                    end else if (rmc_step == FD_UTC && b == CH_DOT) begin
                        rmc_step = FD_FRAC_FIRST;
                    end else begin
                        rmc_step = FD_STOP;
                    end
                end
                FD_FRAC_FIRST, FD_FRAC: begin
                    if (is_decimal(b)) begin
                        rmc_step = FD_FRAC;
                    end else if (rmc_step == FD_FRAC && b == CH_COMMA) begin
                        rmc_step = FD_STATUS;
                    end else begin
                        rmc_step = FD_STOP;
                    end
                end
                FD_STATUS: begin
                    status_byte = b;
                    rmc_step    = FD_HELD;
                end
                default: ;
            endcase
        end
    endtask

    // Takes one received byte; a line end queues the verdict for that line.
    task automatic absorb_byte(input logic [BYTE_W-1:0] b);
        t_line_verdict v;
        if (b == CH_NEWLINE || int'(held_bytes) >= LINE_STORE_BYTES) begin
            v.checksum_ok = (sum_phase == PH_DONE)
                            && (check_hi == nibble_ascii(sum_xor[7:4]))
                            && (check_lo == nibble_ascii(sum_xor[3:0]));
            v.rmc_found   = v.checksum_ok && (tag_pos == PREFIX_LEN);
            v.fix_active  = v.rmc_found && (rmc_step == FD_HELD)
                            && (status_byte == CH_UPPER_A);
            v.utc_time    = v.rmc_found ? utc_value : '0;
            verdict_q.push_back(v);
            clear_line();
        end else begin
            track_checksum(b);
            track_rmc(b);
            held_bytes = held_bytes + 1'b1;
        end
    endtask

    task automatic check_field(input string name, input logic [UTC_W-1:0] want,
                               input logic [UTC_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            fault_count++;
        end
    endtask

    // Results are compared before the byte of the same edge is absorbed; a
    // result never leaves in the cycle of its own line end.
    always @(posedge i_clk) begin
        t_line_verdict want;
        if (!i_rst_n) begin
            verdict_q.delete();
            clear_line();
        end else begin
            if (i_results.valid && i_results.ready) begin
                if (verdict_q.size() == 0) begin
                    $error("result item arrived with no line outstanding");
                    fault_count++;
                end else begin
                    want = verdict_q.pop_front();
                    check_field("checksum_ok", UTC_W'(want.checksum_ok),
                                UTC_W'(i_results.checksum_ok));
                    check_field("rmc_found", UTC_W'(want.rmc_found),
                                UTC_W'(i_results.rmc_found));
                    check_field("fix_active", UTC_W'(want.fix_active),
                                UTC_W'(i_results.fix_active));
                    check_field("utc_time", want.utc_time, i_results.utc_time);
                end
            end
            if (i_bytes.valid && i_bytes.ready) begin
                absorb_byte(i_bytes.rx_byte);
            end
        end
        o_pending    <= verdict_q.size();
        o_fail_count <= fault_count;
    end

endmodule

@@ tb/sv/nmea_rmc_sentence_checker_top_tb.sv @@
`timescale 1ns / 1ps

module nmea_rmc_sentence_checker_top_tb;
    import nrsc_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_BYTES   = 800;
    localparam int RANDOM_LINES   = 20;
    localparam int SETTLE_CYCLES  = 8;

    // How the check characters of a sentence are written.
    typedef enum {
        CK_GOOD,
        CK_WRONG,
        CK_LOWER,
        CK_SHORT,
        CK_NONE
    } t_check_mode;

    logic i_clk;
    logic i_rst_n;

    nrsc_in_if  bytes_ch ();
    nrsc_out_if results_ch ();

    int          fail_count;
    int          pending_lines;
    logic [7:0]  line_buf [$];
    int          burst_left;
    bit          gaps_on;
    bit          stalls_on;
    int          bytes_sent;
    int          lines_sent;

    nmea_rmc_sentence_checker_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (bytes_ch),
        .o_out   (results_ch)
    );

    nrsc_line_checker line_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_bytes      (bytes_ch),
        .i_results    (results_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_lines)
    );

    // Clock generation.
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // The result receiver stalls on a rotating mask that is redrawn now and then.
    initial begin
        logic [15:0] stall_mask;
        int          tick;
        results_ch.ready = 1'b0;
        stall_mask = 16'hFFFF;
        tick = 0;
        forever begin
            @(negedge i_clk);
            tick++;
            if (tick % 48 == 0) begin
                if ($urandom_range(0, 3) == 0) begin
                    stall_mask = 16'h0001 << $urandom_range(0, 15);
                end else begin
                    stall_mask = 16'($urandom()) | 16'h0001;
                end
            end
            results_ch.ready <= !stalls_on || stall_mask[0];
            stall_mask = {stall_mask[0], stall_mask[15:1]};
        end
    end

    // Watchdog: too many cycles without any item moving ends the run.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((bytes_ch.valid && bytes_ch.ready) || (results_ch.valid && results_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // Sends one byte; with gaps on, bursts of random length are split by random gaps.
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            if (gaps_on) begin
                gap = $urandom_range(1, 5);
                @(negedge i_clk);
                bytes_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        bytes_ch.valid   <= 1'b1;
        bytes_ch.rx_byte <= b;
        do @(posedge i_clk); while (!bytes_ch.ready);
        burst_left--;
        bytes_sent++;
        if (b == CH_NEWLINE) begin
            lines_sent++;
        end
    endtask

    task automatic send_line();
        foreach (line_buf[k]) begin
            send_byte(line_buf[k]);
        end
        line_buf.delete();
    endtask

    // Holds the sender off until every outstanding line has its result.
    task automatic drain_results();
        @(negedge i_clk);
        bytes_ch.valid <= 1'b0;
        while (pending_lines != 0) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic put_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            line_buf.push_back(s[k]);
        end
    endtask

    task automatic start_line(input string s);
        line_buf.delete();
        put_text(s);
    endtask

    task automatic finish_line(input string tail);
        put_text(tail);
        send_line();
    endtask

    task automatic put_digits(input int n);
        repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
    endtask

    // Printable filler that never contains the checksum delimiter.
    task automatic put_filler(input int n);
        logic [7:0] c;
        repeat (n) begin
            c = 8'($urandom_range(8'h20, 8'h7E));
            line_buf.push_back((c == CH_STAR) ? CH_COMMA : c);
        end
    endtask

    task automatic pad_to(input int n);
        if (line_buf.size() < n) begin
            put_filler(n - line_buf.size());
        end
    endtask

    // Appends '*' and, by mode, check characters for all bytes after the first.
    task automatic put_checksum(input t_check_mode mode);
        logic [7:0] acc;
        logic [7:0] hi;
        logic [7:0] lo;
        acc = '0;
        for (int k = 1; k < line_buf.size(); k++) begin
            acc = acc ^ line_buf[k];
        end
        hi = hex_char(acc[7:4]);
        lo = hex_char(acc[3:0]);
        case (mode)
            CK_WRONG: begin
                lo = hex_char(acc[3:0] ^ 4'($urandom_range(1, 15)));
            end
            CK_LOWER: begin
                if (hi >= CH_UPPER_A) hi = hi + 8'h20;
                if (lo >= CH_UPPER_A) lo = lo + 8'h20;
            end
            default: ;
        endcase
        line_buf.push_back(CH_STAR);
        if (mode != CK_NONE) begin
            line_buf.push_back(hi);
        end
        if (mode != CK_NONE && mode != CK_SHORT) begin
            line_buf.push_back(lo);
        end
    endtask

    function automatic t_check_mode pick_check_mode();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75) return CK_GOOD;
        if (r < 85) return CK_WRONG;
        if (r < 90) return CK_LOWER;
        if (r < 95) return CK_SHORT;
        return CK_NONE;
    endfunction

    // Optional ignored bytes after the check characters, then the newline.
    task automatic put_tail();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) begin
            line_buf.push_back(8'h0D);
        end else if (r < 36) begin
            put_filler($urandom_range(1, 6));
        end
        line_buf.push_back(CH_NEWLINE);
    endtask

    // Mostly well-formed RMC sentences with random content.
    task automatic build_rmc_line();
        int r;
        start_line("$GPRMC");
        if ($urandom_range(0, 99) < 95) begin
            line_buf.push_back(CH_COMMA);
        end else begin
            line_buf.push_back(8'($urandom_range(0, 255)));
        end
        r = $urandom_range(0, 99);
        put_digits((r < 5) ? 0 : (r < 15) ? $urandom_range(7, 9) : $urandom_range(1, 6));
        if ($urandom_range(0, 99) < 92) line_buf.push_back(CH_DOT);
        put_digits(($urandom_range(0, 99) < 8) ? 0 : $urandom_range(1, 3));
        if ($urandom_range(0, 99) < 95) line_buf.push_back(CH_COMMA);
        r = $urandom_range(0, 99);
        if (r < 60) begin
            line_buf.push_back(CH_UPPER_A);
        end else if (r < 90) begin
            put_text("V");
        end else begin
            line_buf.push_back(8'($urandom_range(1, 255)));
        end
        repeat ($urandom_range(0, 4)) begin
            line_buf.push_back(CH_COMMA);
            put_filler($urandom_range(0, 10));
        end
        if ($urandom_range(0, 99) < 5) begin
            put_filler($urandom_range(60, 110));
        end
        if ($urandom_range(0, 99) < 4) begin
            line_buf.insert($urandom_range(1, line_buf.size() - 1), CH_NUL);
        end
        put_checksum(pick_check_mode());
        put_tail();
    endtask

    // Sentences of other types, and prefixes that only nearly match RMC.
    task automatic build_other_line();
        case ($urandom_range(0, 5))
            0:       start_line("$GPGGA");
            1:       start_line("$GPRMB");
            2:       start_line("$GPRM");
            3:       start_line("$GNRMC");
            4:       start_line("$GPGSV");
            default: start_line("$GPRMCA");
        endcase
        repeat ($urandom_range(0, 6)) begin
            line_buf.push_back(CH_COMMA);
            put_filler($urandom_range(0, 9));
        end
        put_checksum(pick_check_mode());
        put_tail();
    endtask

    // Raw bytes of any value; now and then long enough to fill the line store.
    task automatic build_noise_line();
        int n;
        line_buf.delete();
        n = ($urandom_range(0, 99) < 4) ? $urandom_range(130, 200) : $urandom_range(1, 40);
        if ($urandom_range(0, 1) == 1) begin
            line_buf.push_back(CH_DOLLAR);
        end
        repeat (n) line_buf.push_back(8'($urandom_range(0, 255)));
        if ($urandom_range(0, 99) < 70) begin
            line_buf.push_back(CH_NEWLINE);
        end
    endtask

    // An RMC sentence cut short at a random point.
    task automatic build_broken_line();
        int cut;
        build_rmc_line();
        cut = $urandom_range(1, line_buf.size() - 2);
        while (line_buf.size() > cut) void'(line_buf.pop_back());
        line_buf.push_back(CH_NEWLINE);
    endtask

    // Directed sentences: extremes and each special case of the grammar.
    task automatic run_directed();
        // Empty line and the shortest passing sentence.
        start_line("");
        finish_line("\n");
        start_line("$");
        put_checksum(CK_GOOD);
        finish_line("\n");

        // Complete RMC sentences with an active and a void fix.
        start_line("$GPRMC,123519.00,A,4807.038,N,01131.000,E");
        put_checksum(CK_GOOD);
        finish_line("\r\n");
        start_line("$GPRMC,235959.5,V,,,");
        put_checksum(CK_GOOD);
        finish_line("\n");

        // Wrong, lower-case, half and missing check characters.
        start_line("$GPRMC,000000.0,A");
        put_checksum(CK_WRONG);
        finish_line("\n");
        start_line("$GPRMC,101010.1,A,ZZ");
        put_checksum(CK_LOWER);
        finish_line("\n");
        start_line("$GPRMC,1.0,A");
        put_checksum(CK_SHORT);
        finish_line("\n");
        start_line("$GPRMC,1.0,A");
        put_checksum(CK_NONE);
        finish_line("\n");

        // No leading dollar sign.
        start_line("GPRMC,1.0,A");
        put_checksum(CK_GOOD);
        finish_line("\n");

        // A zero byte inside the text, and one in place of a check character.
        start_line("$GPRMC,12");
        line_buf.push_back(CH_NUL);
        put_text("3.0,A");
        put_checksum(CK_GOOD);
        finish_line("\n");
        start_line("$GPRMC,1.0,A*");
        line_buf.push_back(CH_NUL);
        finish_line("4\n");

        // UTC digits missing, saturating, without fraction and with an empty one.
        start_line("$GPRMC,.5,A");
        put_checksum(CK_GOOD);
        finish_line("\n");
        start_line("$GPRMC,9999999999.0,A");
        put_checksum(CK_GOOD);
        finish_line("\n");
        start_line("$GPRMC,123456,A");
        put_checksum(CK_GOOD);
        finish_line("\n");
        start_line("$GPRMC,12.,A");
        put_checksum(CK_GOOD);
        finish_line("\n");

        // Checksum delimiter just inside and just past the sentence limit.
        start_line("$GPRMC,1.0,A,");
        pad_to(MAX_SENTENCE_BYTES_DEF - 1);
        put_checksum(CK_GOOD);
        finish_line("\n");
        start_line("$GPRMC,1.0,A,");
        pad_to(MAX_SENTENCE_BYTES_DEF);
        put_checksum(CK_GOOD);
        finish_line("\n");

        // Full line store: the next byte ends the line and is dropped.
        start_line("$GPRMC,1.0,A,");
        pad_to(LINE_STORE_BYTES_DEF);
        finish_line("Z\n");

        // Other sentence type, trailing bytes, bit extremes and bare prefix.
        start_line("$GPGGA,1.0,A");
        put_checksum(CK_GOOD);
        finish_line("\n");
        start_line("$GPRMC,1.0,A");
        put_checksum(CK_GOOD);
        finish_line("junk\r\n");
        start_line("$");
        line_buf.push_back(8'hFF);
        line_buf.push_back(8'h80);
        line_buf.push_back(8'h01);
        put_checksum(CK_GOOD);
        finish_line("\n");
        start_line("$GPRMC");
        put_checksum(CK_GOOD);
        finish_line("\n");
    endtask

    // Stimulus and verdict.
    initial begin
        int base_bytes;
        int base_lines;
        int r;
        bytes_ch.valid   = 1'b0;
        bytes_ch.rx_byte = '0;
        i_rst_n          = 1'b0;
        burst_left       = 0;
        gaps_on          = 1'b1;
        stalls_on        = 1'b1;
        bytes_sent       = 0;
        lines_sent       = 0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();
        drain_results();

        // Three random phases: no idling, idling on both sides, output stalls only.
        base_bytes = bytes_sent;
        base_lines = lines_sent;
        for (int ph = 0; ph < 3; ph++) begin
            gaps_on   = (ph == 1);
            stalls_on = (ph != 0);
            while (bytes_sent < base_bytes + (ph + 1) * RANDOM_BYTES / 3
                   || (ph == 2 && lines_sent < base_lines + RANDOM_LINES)) begin
                r = $urandom_range(0, 99);
                if (r < 55) begin
                    build_rmc_line();
                end else if (r < 75) begin
                    build_other_line();
                end else if (r < 90) begin
                    build_noise_line();
                end else begin
                    build_broken_line();
                end
                send_line();
            end
            drain_results();
        end

        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending_lines == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
